// File: src/ordered_list_table_engine_top_assert.svh
// assertion macros for the ordered list table engine
// both expect clk and arst_n in scope
`ifndef ORDERED_LIST_TABLE_ENGINE_TOP_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define OLTE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define OLTE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OLTE_ASSERT_SAME(lbl, ante, cons, msg)
`define OLTE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: src/olte_pkg.sv
`default_nettype none

package olte_pkg;

	typedef enum logic [2:0] {
		MODE_APPEND    = 3'd0,
		MODE_PREPEND   = 3'd1,
		MODE_INSERT    = 3'd2,
		MODE_DELETE    = 3'd3,
		MODE_POP_LAST  = 3'd4,
		MODE_POP_FIRST = 3'd5,
		MODE_FIND      = 3'd6,
		MODE_OVERWRITE = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_FULL      = 3'd1,
		STAT_EMPTY     = 3'd2,
		STAT_BAD_POS   = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_PLACE,
		S_SHIFT_DOWN,
		S_SEARCH,
		S_DONE
	} state_t;

	typedef struct packed {
		mode_t              mode;
		logic [8:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] found_index;
		logic [8:0] item_count;
	} rsp_t;

endpackage

`default_nettype wire

// File: src/olte_ram.sv
`default_nettype none

module olte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: src/ordered_list_table_engine_top.sv
// append, pop last, overwrite and any error go from idle straight to the done state
// insert and prepend shift entries up from the position, one entry moved per cycle
// delete and pop first shift the entries above the position down by one
// find reads entries from index 0 up to the first match, or to the last entry on a miss
// one request at a time; the entry ram has one write and one registered read port
// reset clears the count, the sequencer and the output valid flag; entries are not cleared
`default_nettype none
`include "ordered_list_table_engine_top_assert.svh"

module ordered_list_table_engine_top #(
	parameter int DEPTH = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire olte_pkg::req_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output olte_pkg::rsp_t     out_data
);

	import olte_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > 9) ? CW : 9;

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [AW-1:0]   ptr_q, ptr_d;
	logic [AW-1:0]   at_q, at_d;
	logic [31:0]     val_q, val_d;
	status_t         st_q, st_d;
	logic [AW-1:0]   fnd_q, fnd_d;
	rsp_t            out_q;
	logic            out_valid_q;
	logic            out_load;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	logic [31:0]     mem_wdata;
	logic            mem_re;
	logic [AW-1:0]   mem_raddr;
	logic [31:0]     mem_rdata;

	logic [PW-1:0]   cnt_w;
	logic [PW-1:0]   pos_w;
	logic [PW-1:0]   ins_at;
	logic [PW-1:0]   del_at;
	logic [AW-1:0]   last_idx;
	logic            full;
	logic            empty;
	logic            accept;

	assign cnt_w    = PW'(count_q);
	assign pos_w    = PW'(in_data.position);
	assign last_idx = AW'(count_q - CW'(1));
	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		case (in_data.mode)
			MODE_APPEND:  ins_at = cnt_w;
			MODE_PREPEND: ins_at = '0;
			default:      ins_at = pos_w;
		endcase
		del_at = (in_data.mode == MODE_DELETE) ? pos_w : '0;
	end

	olte_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		at_q  <= at_d;
		val_q <= val_d;
		st_q  <= st_d;
		fnd_q <= fnd_d;
		if (out_load) begin
			out_q.status      <= st_q;
			out_q.found_index <= 8'(fnd_q);
			out_q.item_count  <= 9'(count_q);
		end
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		at_d      = at_q;
		val_d     = val_q;
		st_d      = st_q;
		fnd_d     = fnd_q;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = val_q;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_d   = in_data.value;
					st_d    = STAT_OK;
					fnd_d   = '0;
					state_d = S_DONE;
					case (in_data.mode)
						MODE_APPEND, MODE_PREPEND, MODE_INSERT: begin
							if (full) begin
								st_d = STAT_FULL;
							end else if (ins_at > cnt_w) begin
								st_d = STAT_BAD_POS;
							end else if (ins_at == cnt_w) begin
								mem_we    = 1'b1;
								mem_waddr = AW'(count_q);
								mem_wdata = in_data.value;
								count_d   = count_q + CW'(1);
							end else begin
								mem_re    = 1'b1;
								mem_raddr = last_idx;
								ptr_d     = last_idx;
								at_d      = AW'(ins_at);
								state_d   = S_SHIFT_UP;
							end
						end
						MODE_DELETE, MODE_POP_FIRST: begin
							if (empty) begin
								st_d = STAT_EMPTY;
							end else if (del_at >= cnt_w) begin
								st_d = STAT_BAD_POS;
							end else if (del_at == cnt_w - PW'(1)) begin
								count_d = count_q - CW'(1);
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(del_at + PW'(1));
								ptr_d     = AW'(del_at + PW'(1));
								state_d   = S_SHIFT_DOWN;
							end
						end
						MODE_POP_LAST: begin
							if (empty) begin
								st_d = STAT_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						MODE_FIND: begin
							if (empty) begin
								st_d = STAT_NOT_FOUND;
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								ptr_d     = '0;
								state_d   = S_SEARCH;
							end
						end
						MODE_OVERWRITE: begin
							if (empty) begin
								st_d = STAT_EMPTY;
							end else if (pos_w >= cnt_w) begin
								st_d = STAT_BAD_POS;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(in_data.position);
								mem_wdata = in_data.value;
							end
						end
						default: begin
							st_d = STAT_BAD_POS;
						end
					endcase
				end
			end
			S_SHIFT_UP: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q + AW'(1);
				mem_wdata = mem_rdata;
				if (ptr_q == at_q) begin
					state_d = S_PLACE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q - AW'(1);
					ptr_d     = ptr_q - AW'(1);
				end
			end
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = at_q;
				mem_wdata = val_q;
				count_d   = count_q + CW'(1);
				state_d   = S_DONE;
			end
			S_SHIFT_DOWN: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q - AW'(1);
				mem_wdata = mem_rdata;
				if (ptr_q == last_idx) begin
					count_d = count_q - CW'(1);
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q + AW'(1);
					ptr_d     = ptr_q + AW'(1);
				end
			end
			S_SEARCH: begin
				if (mem_rdata == val_q) begin
					fnd_d   = ptr_q;
					st_d    = STAT_OK;
					state_d = S_DONE;
				end else if (ptr_q == last_idx) begin
					st_d    = STAT_NOT_FOUND;
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q + AW'(1);
					ptr_d     = ptr_q + AW'(1);
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`OLTE_ASSERT_SAME(a_count_range, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`OLTE_ASSERT_SAME(a_rw_apart, mem_we && mem_re, mem_waddr != mem_raddr, "ram read and write collide")
	`OLTE_ASSERT_NEXT(a_accept_busy, accept, !in_ready, "ready right after a transfer")
	`OLTE_ASSERT_SAME(a_place_room, state_q == S_PLACE, !full, "insert into a full list")

endmodule

`default_nettype wire
